// ----- hw/rtl/utf8d_pkg.sv -----
// Package for the UTF-8 to 16-bit code unit decoder.
// Holds the shared types and byte-class constants; no dependencies.
package utf8d_pkg;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int PART_W  = 10;
    localparam int PEND_W  = 2;

    localparam logic [UNIT_W-1:0] LIMIT_RESET = 16'hFFFF;

    // Byte classes and payload masks.
    localparam logic [BYTE_W-1:0] ASCII_END   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD_START  = 8'hC0;
    localparam logic [BYTE_W-1:0] HIGH_NIB    = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD2_HI    = 8'hD0;
    localparam logic [BYTE_W-1:0] LEAD3       = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'h0F;
    localparam logic [BYTE_W-1:0] CONT_MASK   = 8'h3F;

    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;

    typedef struct packed {
        logic [PEND_W-1:0] pending;
        logic [PART_W-1:0] partial;
        logic [UNIT_W-1:0] units;
    } dec_state_t;

    typedef struct packed {
        logic              unit_valid;
        logic [UNIT_W-1:0] code_unit;
        logic              text_done;
        logic [UNIT_W-1:0] unit_count;
    } result_t;

endpackage

// ----- hw/rtl/utf8d_decode.sv -----
// Combinational decode of one byte against the current text state.
// Depends on utf8d_pkg for the state and result types.
module utf8d_decode (
    input  utf8d_pkg::dec_state_t             state,
    input  logic [utf8d_pkg::BYTE_W-1:0]      in_byte,
    input  logic                              last,
    input  logic [utf8d_pkg::UNIT_W-1:0]      limit,
    output utf8d_pkg::dec_state_t             state_next,
    output utf8d_pkg::result_t                result,
    output logic                              emit
);
    import utf8d_pkg::*;

    logic              have_unit;
    logic [UNIT_W-1:0] unit;
    logic [UNIT_W-1:0] shifted;
    logic [BYTE_W-1:0] nib;
    dec_state_t        work;

    assign shifted = {state.partial, in_byte[5:0]};
    assign nib     = in_byte & HIGH_NIB;

    always_comb
    begin
        work      = state;
        have_unit = 1'b0;
        unit      = '0;
        if (state.units < limit)
        begin
            if (state.pending != PEND_NONE)
            begin
                work.pending = state.pending - PEND_ONE;
                if (state.pending == PEND_ONE)
                begin
                    unit         = shifted;
                    work.partial = '0;
                    have_unit    = 1'b1;
                end
                else
                begin
                    work.partial = shifted[PART_W-1:0];
                end
            end
            else if (in_byte < ASCII_END)
            begin
                unit      = {{(UNIT_W-BYTE_W){1'b0}}, in_byte};
                have_unit = 1'b1;
            end
            else if (in_byte < LEAD_START)
            begin
                // Stray continuation byte: nothing to do.
            end
            else if (nib == LEAD_START || nib == LEAD2_HI)
            begin
                work.partial = {{(PART_W-BYTE_W){1'b0}}, in_byte & LEAD2_MASK};
                work.pending = PEND_ONE;
            end
            else if (nib == LEAD3)
            begin
                work.partial = {{(PART_W-BYTE_W){1'b0}}, in_byte & LEAD3_MASK};
                work.pending = PEND_TWO;
            end
        end
        if (have_unit)
        begin
            work.units = state.units + UNIT_W'(1);
        end

        result.unit_valid = have_unit;
        result.code_unit  = unit;
        result.text_done  = last;
        result.unit_count = work.units;
        emit              = have_unit | last;

        if (last)
        begin
            state_next = '0;
        end
        else
        begin
            state_next = work;
        end
    end

endmodule

// ----- hw/rtl/utf8d_out_reg.sv -----
// Result register on the output channel with valid/stall handshake.
// Depends on utf8d_pkg for the result type.
module utf8d_out_reg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  utf8d_pkg::result_t            result,
    output logic                          free,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          unit_valid,
    output logic [utf8d_pkg::UNIT_W-1:0]  code_unit,
    output logic                          text_done,
    output logic [utf8d_pkg::UNIT_W-1:0]  unit_count
);
    import utf8d_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // The register can take a new item when empty or when its item leaves now.
    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign unit_valid = data_reg.unit_valid;
    assign code_unit  = data_reg.code_unit;
    assign text_done  = data_reg.text_done;
    assign unit_count = data_reg.unit_count;

endmodule

// ----- hw/rtl/utf8_to_ucs2_stream_decoder.sv -----
// UTF-8 to 16-bit code unit decoder, one byte per item.
// An accepted byte lands in an input register at its accepting edge, is decoded
// against the text state combinationally, and its result, if any, is loaded into
// the result register once that register is free. A new byte can be taken while
// an earlier result still waits in the result register. A new byte is taken every
// cycle while the result register drains. Only a stalled result register holds up the input.
// limit_reg is written through cfg_wr_en/cfg_wr_data; the user must write it only while idle (not enforced here).
// Depends on utf8d_pkg, utf8d_decode and utf8d_out_reg.
module utf8_to_ucs2_stream_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [utf8d_pkg::UNIT_W-1:0]  cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [utf8d_pkg::BYTE_W-1:0]  in_byte,
    input  logic                          end_of_text,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          unit_valid,
    output logic [utf8d_pkg::UNIT_W-1:0]  code_unit,
    output logic                          text_done,
    output logic [utf8d_pkg::UNIT_W-1:0]  unit_count
);
    import utf8d_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic [UNIT_W-1:0] limit_reg;
    dec_state_t        state_reg;
    dec_state_t        state_next;
    result_t           result;
    logic              emit;
    logic              free;
    logic              advance;
    logic              in_take;

    utf8d_decode u_decode (
        .state      (state_reg),
        .in_byte    (in_byte_reg),
        .last       (in_last_reg),
        .limit      (limit_reg),
        .state_next (state_next),
        .result     (result),
        .emit       (emit)
    );

    // A byte that yields no result never waits for the result register.
    assign advance  = in_valid_reg && (!emit || free);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else
        begin
            in_valid_next = in_valid_reg && !advance;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
            limit_reg    <= LIMIT_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= end_of_text;
        end
    end

    utf8d_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && emit),
        .result     (result),
        .free       (free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .unit_valid (unit_valid),
        .code_unit  (code_unit),
        .text_done  (text_done),
        .unit_count (unit_count)
    );

    a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pending != 2'd3)
        else $error("pending count out of range");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=>
        (state_reg.units == '0 && state_reg.pending == PEND_NONE))
        else $error("text state not cleared after end of text");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit) |=> out_valid)
        else $error("result lost on its way to the output register");

    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> !in_stall)
        else $error("input stalled with an empty input register");

endmodule
